/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stuck-bus recovery checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

/* rtl/i2csbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csbr_pkg
// Types, register indexes and defaults shared by the stuck-bus recovery block
// ----------------------------------------------------------------------------
package i2csbr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PULSE_W    = 4;

	localparam int MAX_PULSES_DEF  = 9;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_PRESENT     = 2'd2;

	localparam logic [31:0] CHECK_INTERVAL_RST  = 32'd60000;
	localparam logic [31:0] STUCK_THRESHOLD_RST = 32'd300000;
	localparam logic        BUS_PRESENT_RST     = 1'b1;

	typedef struct packed {
		logic [31:0] check_interval;
		logic [31:0] stuck_threshold;
		logic        bus_present;
	} cfg_t;

	typedef struct packed {
		logic scl_release;
		logic sda_release;
		logic controller_detached;
		logic recovered;
	} result_t;

endpackage

/* rtl/i2csbr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csbr_if
// Valid/ready channels for line samples and recovery results
// ----------------------------------------------------------------------------
interface i2csbr_in_if;
	logic valid;
	logic ready;
	logic sda_level;
	logic scl_level;

	modport source (output valid, output sda_level, output scl_level, input ready);
	modport sink (input valid, input sda_level, input scl_level, output ready);
endinterface

interface i2csbr_out_if;
	logic valid;
	logic ready;
	logic scl_release;
	logic sda_release;
	logic controller_detached;
	logic recovered;

	modport source (output valid, output scl_release, output sda_release,
		output controller_detached, output recovered, input ready);
	modport sink (input valid, input scl_release, input sda_release,
		input controller_detached, input recovered, output ready);
endinterface

/* rtl/i2csbr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csbr_cfg
// Configuration register file, write only
// ----------------------------------------------------------------------------
module i2csbr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2csbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2csbr_pkg::CFG_DATA_W-1:0] cfg_data,
	output i2csbr_pkg::cfg_t                 cfg
);

	i2csbr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval  <= i2csbr_pkg::CHECK_INTERVAL_RST;
			cfg_q.stuck_threshold <= i2csbr_pkg::STUCK_THRESHOLD_RST;
			cfg_q.bus_present     <= i2csbr_pkg::BUS_PRESENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2csbr_pkg::REG_CHECK_INTERVAL:  cfg_q.check_interval  <= cfg_data;
				i2csbr_pkg::REG_STUCK_THRESHOLD: cfg_q.stuck_threshold <= cfg_data;
				i2csbr_pkg::REG_BUS_PRESENT:     cfg_q.bus_present     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/i2csbr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csbr_core
// Low-age tracking, stuck detection and clock-pulse bus-clear sequencer
// ----------------------------------------------------------------------------
module i2csbr_core #(
	parameter int MAX_PULSES  = i2csbr_pkg::MAX_PULSES_DEF,
	parameter int COUNT_WIDTH = i2csbr_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 sda_level,
	input  logic                 scl_level,
	input  i2csbr_pkg::cfg_t     cfg,
	output i2csbr_pkg::result_t  result
);

	localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam int PW    = i2csbr_pkg::PULSE_W;

	localparam logic [2:0] PH_MONITOR    = 3'd0;
	localparam logic [2:0] PH_DECIDE     = 3'd1;
	localparam logic [2:0] PH_PULSE_HIGH = 3'd2;
	localparam logic [2:0] PH_STOP_HOLD  = 3'd3;
	localparam logic [2:0] PH_STOP_RISE  = 3'd4;

	logic [2:0]             phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] interval_q, interval_n;
	logic                   sda_seen_q, sda_seen_n;
	logic [COUNT_WIDTH-1:0] sda_age_q, sda_age_n;
	logic                   scl_seen_q, scl_seen_n;
	logic [COUNT_WIDTH-1:0] scl_age_q, scl_age_n;
	logic [PW-1:0]          pulse_q, pulse_n;
	logic                   stuck;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		interval_n = sat_inc(interval_q);
		sda_seen_n = sda_seen_q;
		scl_seen_n = scl_seen_q;
		sda_age_n  = sda_seen_q ? sat_inc(sda_age_q) : sda_age_q;
		scl_age_n  = scl_seen_q ? sat_inc(scl_age_q) : scl_age_q;
		pulse_n    = pulse_q;
		phase_n    = phase_q;
		stuck      = 1'b0;
		result     = '{scl_release: 1'b1, sda_release: 1'b1,
			controller_detached: 1'b0, recovered: 1'b0};

		case (phase_q)
			PH_DECIDE: begin
				result.controller_detached = 1'b1;
				if (!sda_level && (pulse_q < PW'(MAX_PULSES))) begin
					pulse_n            = pulse_q + 1'b1;
					phase_n            = PH_PULSE_HIGH;
					result.scl_release = 1'b0;
				end else begin
					phase_n            = PH_STOP_HOLD;
					result.sda_release = 1'b0;
				end
			end
			PH_PULSE_HIGH: begin
				phase_n                    = PH_DECIDE;
				result.controller_detached = 1'b1;
			end
			PH_STOP_HOLD: begin
				phase_n                    = PH_STOP_RISE;
				result.controller_detached = 1'b1;
				result.sda_release         = 1'b0;
			end
			PH_STOP_RISE: begin
				phase_n                    = PH_MONITOR;
				sda_seen_n                 = 1'b0;
				sda_age_n                  = '0;
				scl_seen_n                 = 1'b0;
				scl_age_n                  = '0;
				pulse_n                    = '0;
				result.controller_detached = 1'b1;
				result.recovered           = 1'b1;
			end
			default: begin
				phase_n = PH_MONITOR;
				// check falls due once the interval count reaches the register
				if (cfg.bus_present &&
					(CMP_W'(interval_n) >= CMP_W'(cfg.check_interval))) begin
					interval_n = '0;
					if (!sda_level) begin
						if (!sda_seen_q) begin
							sda_seen_n = 1'b1;
							sda_age_n  = '0;
						end
					end else begin
						sda_seen_n = 1'b0;
						sda_age_n  = '0;
					end
					if (!scl_level) begin
						if (!scl_seen_q) begin
							scl_seen_n = 1'b1;
							scl_age_n  = '0;
						end
					end else begin
						scl_seen_n = 1'b0;
						scl_age_n  = '0;
					end
					stuck = (sda_seen_n &&
						(CMP_W'(sda_age_n) > CMP_W'(cfg.stuck_threshold))) ||
						(scl_seen_n &&
						(CMP_W'(scl_age_n) > CMP_W'(cfg.stuck_threshold)));
					if (stuck) begin
						pulse_n                    = '0;
						phase_n                    = PH_DECIDE;
						result.controller_detached = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MONITOR;
			interval_q <= '0;
			sda_seen_q <= 1'b0;
			sda_age_q  <= '0;
			scl_seen_q <= 1'b0;
			scl_age_q  <= '0;
			pulse_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			interval_q <= interval_n;
			sda_seen_q <= sda_seen_n;
			sda_age_q  <= sda_age_n;
			scl_seen_q <= scl_seen_n;
			scl_age_q  <= scl_age_n;
			pulse_q    <= pulse_n;
		end
	end

endmodule

/* rtl/i2c_stuck_bus_recovery.sv */
`timescale 1ns / 1ps
// a result beat is offered from the result register once its sample has passed the input register
// throughput: one sample beat per cycle while the result channel is not stalled, with the state update
// between the input register and the result register
// a stalled result register holds its beat while one more sample waits in the input register
// reset: asynchronous, active low; registers return to defaults, monitoring, counters zero
// ----------------------------------------------------------------------------
// i2c_stuck_bus_recovery
// I2C stuck-bus watchdog with clock-pulse bus-clear recovery and manual STOP
// ----------------------------------------------------------------------------
module i2c_stuck_bus_recovery #(
	parameter int MAX_PULSES  = i2csbr_pkg::MAX_PULSES_DEF,
	parameter int COUNT_WIDTH = i2csbr_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	i2csbr_in_if.sink                         in_bus,
	i2csbr_out_if.source                      out_bus,
	input  logic                              cfg_we,
	input  logic [i2csbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2csbr_pkg::CFG_DATA_W-1:0] cfg_data
);

	i2csbr_pkg::cfg_t    cfg;
	i2csbr_pkg::result_t result;
	i2csbr_pkg::result_t res_q;

	logic valid_s1, sda_s1, scl_s1;
	logic out_valid_q;
	logic advance, step;

	assign advance      = !out_valid_q || out_bus.ready;
	assign step         = valid_s1 && advance;
	assign in_bus.ready = !valid_s1 || advance;

	i2csbr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2csbr_core #(
		.MAX_PULSES  (MAX_PULSES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sda_level (sda_s1),
		.scl_level (scl_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_bus.ready) begin
			valid_s1 <= in_bus.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_bus.ready && in_bus.valid) begin
			sda_s1 <= in_bus.sda_level;
			scl_s1 <= in_bus.scl_level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign out_bus.valid               = out_valid_q;
	assign out_bus.scl_release         = res_q.scl_release;
	assign out_bus.sda_release         = res_q.sda_release;
	assign out_bus.controller_detached = res_q.controller_detached;
	assign out_bus.recovered           = res_q.recovered;

endmodule

/* rtl/i2csbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csbr_checker
// Port-level checks on recovery result beats, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2csbr_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic scl_release,
	input logic sda_release,
	input logic controller_detached,
	input logic recovered
);

	// recovery ends with both lines released while still detached
	`ASSERT_CLK(a_rec_ends_released, clk, arst_n, (out_valid && recovered) |-> (controller_detached && scl_release && sda_release), "recovered beat without released lines")

	// a line is only pulled low while recovery owns the pins
	`ASSERT_NEVER(a_drive_needs_detach, clk, arst_n, out_valid && !controller_detached && (!scl_release || !sda_release), "line driven low while attached")

	// clock pulse and stop never drive both lines at once
	`ASSERT_NEVER(a_no_double_drive, clk, arst_n, out_valid && !scl_release && !sda_release, "both lines pulled low")

	// a stalled beat stays offered unchanged
	`ASSERT_CLK(a_stall_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(scl_release) && $stable(sda_release) && $stable(controller_detached) && $stable(recovered)), "stalled result beat changed")

endmodule

bind i2c_stuck_bus_recovery i2csbr_checker u_i2csbr_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_bus.valid),
	.out_ready           (out_bus.ready),
	.scl_release         (out_bus.scl_release),
	.sda_release         (out_bus.sda_release),
	.controller_detached (out_bus.controller_detached),
	.recovered           (out_bus.recovered)
);

/* bench/bus_clear_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_clear_checker
// Watches the sample and drive channels of the stuck-bus recovery block,
// predicts every drive beat from the accepted samples and the register
// writes, and compares each delivered beat field by field in order.
// ----------------------------------------------------------------------------
module bus_clear_checker #(
	parameter int MAX_PULSES = i2csbr_pkg::MAX_PULSES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	i2csbr_in_if                              smp,
	i2csbr_out_if                             res,
	input  logic                              cfg_we,
	input  logic [i2csbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2csbr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                       fail_count,
	output int unsigned                       pending
);

	typedef enum logic [3:0] {
		PH_MONITOR,
		PH_DECIDE,
		PH_PULSE_HIGH,
		PH_STOP_HOLD,
		PH_STOP_RISE
	} bus_phase_e;

	i2csbr_pkg::cfg_t regs;
	bus_phase_e       bus_phase;
	logic [31:0]      since_check;
	logic             sda_seen;
	logic [31:0]      sda_age;
	logic             scl_seen;
	logic [31:0]      scl_age;
	logic [3:0]       pulses_given;

	i2csbr_pkg::result_t drive_expected[$];
	int unsigned         mismatches = 0;
	int unsigned         drive_beats = 0;

	string field_name[4] = '{"recovered", "controller_detached", "sda_release", "scl_release"};

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// one base tick of the watchdog: returns the pin drive it causes
	function automatic i2csbr_pkg::result_t predict_drive(input logic sda, input logic scl);
		i2csbr_pkg::result_t drv;
		logic                sda_low;
		logic                scl_low;
		sda_low = !sda;
		scl_low = !scl;
		drv     = '{scl_release: 1'b1, sda_release: 1'b1,
			controller_detached: 1'b0, recovered: 1'b0};

		since_check = bump(since_check);
		if (sda_seen)
			sda_age = bump(sda_age);
		if (scl_seen)
			scl_age = bump(scl_age);

		case (bus_phase)
			PH_DECIDE: begin
				drv.controller_detached = 1'b1;
				if (sda_low && pulses_given < MAX_PULSES) begin
					pulses_given    = pulses_given + 4'd1;
					bus_phase       = PH_PULSE_HIGH;
					drv.scl_release = 1'b0;
				end else begin
					bus_phase       = PH_STOP_HOLD;
					drv.sda_release = 1'b0;
				end
				return drv;
			end
			PH_PULSE_HIGH: begin
				bus_phase               = PH_DECIDE;
				drv.controller_detached = 1'b1;
				return drv;
			end
			PH_STOP_HOLD: begin
				bus_phase               = PH_STOP_RISE;
				drv.sda_release         = 1'b0;
				drv.controller_detached = 1'b1;
				return drv;
			end
			PH_STOP_RISE: begin
				bus_phase               = PH_MONITOR;
				sda_seen                = 1'b0;
				sda_age                 = '0;
				scl_seen                = 1'b0;
				scl_age                 = '0;
				pulses_given            = '0;
				drv.controller_detached = 1'b1;
				drv.recovered           = 1'b1;
				return drv;
			end
			default: ;
		endcase

		bus_phase = PH_MONITOR;
		if (!regs.bus_present || since_check < regs.check_interval)
			return drv;
		since_check = '0;

		// age restarts from the first check that sees the line low
		if (sda_low) begin
			if (!sda_seen) begin
				sda_seen = 1'b1;
				sda_age  = '0;
			end
		end else begin
			sda_seen = 1'b0;
			sda_age  = '0;
		end
		if (scl_low) begin
			if (!scl_seen) begin
				scl_seen = 1'b1;
				scl_age  = '0;
			end
		end else begin
			scl_seen = 1'b0;
			scl_age  = '0;
		end

		if ((sda_seen && sda_age > regs.stuck_threshold) ||
			(scl_seen && scl_age > regs.stuck_threshold)) begin
			pulses_given            = '0;
			bus_phase               = PH_DECIDE;
			drv.controller_detached = 1'b1;
		end
		return drv;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		i2csbr_pkg::result_t got;
		i2csbr_pkg::result_t want;
		if (!arst_n) begin
			regs.check_interval  = i2csbr_pkg::CHECK_INTERVAL_RST;
			regs.stuck_threshold = i2csbr_pkg::STUCK_THRESHOLD_RST;
			regs.bus_present     = i2csbr_pkg::BUS_PRESENT_RST;
			bus_phase            = PH_MONITOR;
			since_check          = '0;
			sda_seen             = 1'b0;
			sda_age              = '0;
			scl_seen             = 1'b0;
			scl_age              = '0;
			pulses_given         = '0;
			drive_expected.delete();
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2csbr_pkg::REG_CHECK_INTERVAL:
						regs.check_interval  = cfg_data;
					i2csbr_pkg::REG_STUCK_THRESHOLD:
						regs.stuck_threshold = cfg_data;
					i2csbr_pkg::REG_BUS_PRESENT:
						regs.bus_present     = cfg_data[0];
					default: ;
				endcase
			end
			if (smp.valid && smp.ready)
				drive_expected.push_back(predict_drive(smp.sda_level, smp.scl_level));
			if (res.valid && res.ready) begin
				got = {res.scl_release, res.sda_release, res.controller_detached, res.recovered};
				drive_beats++;
				if (drive_expected.size() == 0) begin
					report_mismatch($sformatf("drive beat %0d arrived with nothing expected",
						drive_beats));
				end else begin
					want = drive_expected.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== want[i])
							report_mismatch($sformatf("drive beat %0d %s: got %b expected %b",
								drive_beats, field_name[i], got[i], want[i]));
					end
				end
			end
			pending    <= drive_expected.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stuck-bus recovery block: register settings from the
// defaults to the extremes, a directed full nine-pulse recovery, then runs
// of held-low lines with random lengths and noise, with random gaps and
// stalls on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 95;
	localparam int DIRECTED_ITEMS = 25;
	localparam logic [i2csbr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [i2csbr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [i2csbr_pkg::CFG_DATA_W-1:0] cfg_data;
	int unsigned                       fail_count;
	int unsigned                       pending;

	// no gaps or stalls while set
	bit   steady = 1'b0;
	int   sda_run = 0;
	int   scl_run = 0;
	logic sda_held = 1'b1;
	logic scl_held = 1'b1;

	i2csbr_in_if  smp_bus ();
	i2csbr_out_if res_bus ();

	i2c_stuck_bus_recovery u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_bus    (smp_bus),
		.out_bus   (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bus_clear_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_bus),
		.res        (res_bus),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// a line holds its level for a run; low runs can be long enough to look stuck
	function automatic logic next_level(inout int run_left, inout logic held, input int max_low);
		if (run_left == 0) begin
			held     = ($urandom_range(0, 99) < 55) ? 1'b0 : 1'b1;
			run_left = held ? $urandom_range(1, 6) : $urandom_range(1, max_low);
		end
		run_left--;
		return held;
	endfunction

	task automatic send_sample(input logic sda, input logic scl);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			smp_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_bus.valid     <= 1'b1;
		smp_bus.sda_level <= sda;
		smp_bus.scl_level <= scl;
		do @(posedge clk); while (!(smp_bus.valid && smp_bus.ready));
	endtask

	// drain every outstanding drive beat, then let the pipeline empty
	task automatic settle();
		smp_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] interval, input logic [31:0] threshold,
		input logic [31:0] present, input bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_index <= i2csbr_pkg::REG_CHECK_INTERVAL;
		cfg_data  <= interval;
		@(posedge clk);
		cfg_index <= i2csbr_pkg::REG_STUCK_THRESHOLD;
		cfg_data  <= threshold;
		@(posedge clk);
		cfg_index <= i2csbr_pkg::REG_BUS_PRESENT;
		cfg_data  <= present;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= $urandom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input int max_low);
		logic sda;
		logic scl;
		repeat (n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				sda = 1'($urandom_range(0, 1));
				scl = 1'($urandom_range(0, 1));
			end else begin
				sda = next_level(sda_run, sda_held, max_low);
				scl = next_level(scl_run, scl_held, max_low);
			end
			send_sample(sda, scl);
		end
		settle();
	endtask

	initial begin : drain
		int unsigned hold;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 7);
			if (hold != 0) begin
				res_bus.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] interval;
		logic [31:0] threshold;
		logic [31:0] present;
		arst_n            <= 1'b0;
		smp_bus.valid     <= 1'b0;
		smp_bus.sda_level <= 1'b1;
		smp_bus.scl_level <= 1'b1;
		cfg_we            <= 1'b0;
		cfg_index         <= i2csbr_pkg::REG_CHECK_INTERVAL;
		cfg_data          <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: no check falls due this early
		run_phase(10, 30);

		// both lines stuck low, then sda held low through all pulses and the stop
		apply_settings(32'd0, 32'd2, 32'd1, 1'b0);
		for (int i = 0; i < DIRECTED_ITEMS; i++)
			send_sample(1'b0, (i < 4) ? 1'b0 : 1'b1);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			present = $urandom;
			present[0] = 1'b1;
			case (p)
				0: begin interval = 32'd1;           threshold = 32'd1;           end
				1: begin interval = 32'd0;           threshold = 32'd0;           end
				2: begin interval = 32'd3;           threshold = 32'd6;           end
				3: begin interval = 32'hFFFF_FFFF;   threshold = 32'd1;           end
				4: begin interval = 32'd1;           threshold = 32'hFFFF_FFFF;   end
				5: begin
					// bus absent, whatever recovery is running still finishes
					interval   = 32'd0;
					threshold  = 32'd0;
					present[0] = 1'b0;
				end
				default: begin
					interval  = $urandom_range(0, 4);
					threshold = $urandom_range(0, 12);
					if ($urandom_range(0, 7) == 0)
						present[0] = 1'b0;
				end
			endcase
			steady = (p % 3 == 2);
			apply_settings(interval, threshold, present, p[0]);
			run_phase(PHASE_ITEMS, 30);
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
